FILE: sv/assert_macros.svh
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/bfa_pkg.sv
package bfa_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_BITS = 24;
	localparam int LEN_W = 25;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	// running end of the table: start plus length, no wrap
	localparam int PEND_W = LEN_W + 1;
	localparam int PADDR_W = 3;

	// request kinds
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE = 1'b1;

	// result codes
	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// register indexes
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(1) << ADDR_BITS;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LEN_W-1:0] length;
	} entry_t;

endpackage

FILE: sv/best_fit_allocator.sv
// Channel   | Direction | Content
// s_axis    | in        | tdata: request_size, free_address; tuser: func
// m_axis    | out       | tdata: granted_address; tuser: status
// apb       | in/out    | register 0 at byte 0: memory_capacity
//
// Allocate scans the table, then checks the tail gap, then places the entry,
// appended or after moving later entries up; with no fit it responds after the
// scan. Free scans for the address and moves later entries down unless it was
// the last one; full, zero size and empty free go straight to the response.
// Reset clears the entry count and loads the capacity reset; no clearing pass.
// A request is taken only in idle; a held result stalls only the next result.
module best_fit_allocator (
	input  logic clk,
	input  logic arst_n,
	// stream in
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [55:0] s_tdata,   // [24:0] request_size, [48:25] free_address, rest 0
	input  logic [0:0] s_tuser,    // [0] func
	// stream out
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,   // [23:0] granted_address
	output logic [1:0] m_tuser,    // [1:0] status
	// configuration
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bfa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_TAIL, S_SHIFT, S_PLACE, S_RESP
	} state_t;

	localparam logic [PEND_W-1:0] CAP_LIM = PEND_W'(1) << ADDR_BITS;

	state_t state_q;
	logic [LEN_W-1:0] cap_q;
	logic func_q;
	logic [LEN_W-1:0] size_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] last_q;
	logic iss_q;
	logic v_s1;
	logic [CNT_W-1:0] idx_s1;
	logic [PEND_W-1:0] prev_end_q;
	logic found_q;
	logic [PEND_W-1:0] best_gap_q;
	logic [ADDR_BITS-1:0] best_addr_q;
	logic [CNT_W-1:0] best_pos_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	status_t res_stat_q;
	logic m_tvalid_q;
	logic [23:0] m_tdata_q;
	status_t m_tuser_q;

	entry_t mem_q [MAX_ENTRIES];
	entry_t rd_data_s1;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t wr_data;

	logic s_xfer;
	logic cfg_wr;
	logic [LEN_W-1:0] in_size;
	logic [ADDR_BITS-1:0] in_addr;
	logic in_func;
	logic [CNT_W-1:0] cnt_m1;
	logic is_last;
	logic [PEND_W-1:0] s_ext;
	logic [PEND_W-1:0] gap_w;
	logic [PEND_W-1:0] end_w;
	logic fits;
	logic match;
	logic [PEND_W-1:0] cap_lim;
	logic [PEND_W-1:0] tail_gap;
	logic tail_take;
	logic fin_found;
	logic [CNT_W-1:0] fin_pos;

	assign in_size = s_tdata[LEN_W-1:0];
	assign in_addr = s_tdata[LEN_W+ADDR_BITS-1:LEN_W];
	assign in_func = s_tuser[0];
	assign s_tready = (state_q == S_IDLE);
	assign s_xfer = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

	// gap in front of the entry just read
	assign cnt_m1 = CNT_W'(cnt_q - 1'b1);
	assign is_last = (idx_s1 == cnt_m1);
	assign s_ext = PEND_W'(rd_data_s1.start);
	assign gap_w = s_ext - prev_end_q;
	assign end_w = s_ext + PEND_W'(rd_data_s1.length);
	assign fits = (s_ext >= prev_end_q) && (gap_w >= PEND_W'(size_q))
		&& (!found_q || gap_w < best_gap_q);
	assign match = (rd_data_s1.start == addr_q);

	// tail gap up to the effective capacity
	assign cap_lim = (PEND_W'(cap_q) > CAP_LIM) ? CAP_LIM : PEND_W'(cap_q);
	assign tail_gap = cap_lim - prev_end_q;
	assign tail_take = (cap_lim > prev_end_q) && (tail_gap >= PEND_W'(size_q))
		&& (!found_q || tail_gap < best_gap_q);
	assign fin_found = found_q || tail_take;
	assign fin_pos = tail_take ? cnt_q : best_pos_q;

	// table write port: shift moves or placement of the new entry
	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_s1[IDX_W-1:0];
		wr_data = rd_data_s1;
		if (state_q == S_SHIFT && v_s1) begin
			wr_en = 1'b1;
			wr_addr = (func_q == FN_FREE) ? IDX_W'(idx_s1 - 1'b1) : IDX_W'(idx_s1 + 1'b1);
		end else if (state_q == S_PLACE) begin
			wr_en = 1'b1;
			wr_addr = best_pos_q[IDX_W-1:0];
			wr_data.start = best_addr_q;
			wr_data.length = size_q;
		end
	end

	// entry table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_idx_q[IDX_W-1:0]];
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q <= CAP_RESET;
			func_q <= FN_ALLOC;
			size_q <= '0;
			addr_q <= '0;
			cnt_q <= '0;
			rd_idx_q <= '0;
			last_q <= '0;
			iss_q <= 1'b0;
			v_s1 <= 1'b0;
			idx_s1 <= '0;
			prev_end_q <= '0;
			found_q <= 1'b0;
			best_gap_q <= '0;
			best_addr_q <= '0;
			best_pos_q <= '0;
			res_addr_q <= '0;
			res_stat_q <= ST_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= ST_OK;
		end else begin
			if (cfg_wr) begin
				cap_q <= pwdata[LEN_W-1:0];
			end
			// drop a result once it has been transferred
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_xfer) begin
						func_q <= in_func;
						size_q <= in_size;
						addr_q <= in_addr;
						res_addr_q <= '0;
						rd_idx_q <= '0;
						v_s1 <= 1'b0;
						prev_end_q <= '0;
						found_q <= 1'b0;
						best_gap_q <= '0;
						best_pos_q <= '0;
						if (in_func == FN_ALLOC) begin
							if (cnt_q == CNT_W'(MAX_ENTRIES)) begin
								res_stat_q <= ST_FULL;
								state_q <= S_RESP;
							end else if (in_size == '0) begin
								res_stat_q <= ST_NOFIT;
								state_q <= S_RESP;
							end else if (cnt_q == '0) begin
								state_q <= S_TAIL;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							if (cnt_q == '0) begin
								res_stat_q <= ST_NOTFOUND;
								state_q <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					// issue reads in table order
					if (rd_idx_q < cnt_q) begin
						rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
						v_s1 <= 1'b1;
						idx_s1 <= rd_idx_q;
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1) begin
						if (func_q == FN_ALLOC) begin
							if (fits) begin
								found_q <= 1'b1;
								best_gap_q <= gap_w;
								best_addr_q <= prev_end_q[ADDR_BITS-1:0];
								best_pos_q <= idx_s1;
							end
							prev_end_q <= end_w;
							if (is_last) begin
								v_s1 <= 1'b0;
								state_q <= S_TAIL;
							end
						end else if (match) begin
							if (is_last) begin
								cnt_q <= cnt_m1;
								res_stat_q <= ST_OK;
								state_q <= S_RESP;
							end else begin
								// close the hole: move later entries down
								rd_idx_q <= CNT_W'(idx_s1 + 1'b1);
								last_q <= cnt_m1;
								iss_q <= 1'b1;
								v_s1 <= 1'b0;
								state_q <= S_SHIFT;
							end
						end else if (is_last) begin
							res_stat_q <= ST_NOTFOUND;
							state_q <= S_RESP;
						end
					end
				end
				S_TAIL: begin
					if (!fin_found) begin
						res_stat_q <= ST_NOFIT;
						state_q <= S_RESP;
					end else begin
						if (tail_take) begin
							best_addr_q <= prev_end_q[ADDR_BITS-1:0];
						end
						best_pos_q <= fin_pos;
						if (fin_pos == cnt_q) begin
							state_q <= S_PLACE;
						end else begin
							// open a slot: move entries up from the end
							rd_idx_q <= cnt_m1;
							last_q <= fin_pos;
							iss_q <= 1'b1;
							v_s1 <= 1'b0;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (iss_q) begin
						v_s1 <= 1'b1;
						idx_s1 <= rd_idx_q;
						if (rd_idx_q == last_q) begin
							iss_q <= 1'b0;
						end else if (func_q == FN_FREE) begin
							rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
						end else begin
							rd_idx_q <= CNT_W'(rd_idx_q - 1'b1);
						end
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1 && idx_s1 == last_q) begin
						v_s1 <= 1'b0;
						if (func_q == FN_FREE) begin
							cnt_q <= cnt_m1;
							res_stat_q <= ST_OK;
							state_q <= S_RESP;
						end else begin
							state_q <= S_PLACE;
						end
					end
				end
				S_PLACE: begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
					res_addr_q <= best_addr_q;
					res_stat_q <= ST_OK;
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= 24'(res_addr_q);
						m_tuser_q <= res_stat_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/bfa_checker.sv
`include "assert_macros.svh"

module bfa_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0] m_tuser
);
	import bfa_pkg::*;

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// one request at a time: a transfer in closes the input for the next cycle
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// only a successful allocate carries an address
	`ASSERT_SAME(a_addr_zero, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tdata == 24'd0)

	// a new result needs a request behind it: none appears while still idle-ready
	`ASSERT_NEXT(a_no_stray_result, clk, arst_n,
		!m_tvalid && s_tready && !(s_tvalid && s_tready), !m_tvalid)

endmodule

bind best_fit_allocator bfa_checker u_bfa_checker (.*);
